// ===== sv/dmpi_pkg.sv =====
// shared types, widths and constants for the dual motor pi speed controller
package dmpi_pkg;

	// hall edge counter width
	localparam int unsigned COUNT_BITS = 16;

	// fixed field widths
	localparam int unsigned TARGET_W = 14;
	localparam int unsigned ADC_W = 12;
	localparam int unsigned GAIN_W = 8;
	localparam int unsigned FB_W = 4;
	localparam int unsigned SPEED_W = 15;
	localparam int unsigned DRIVE_W = 16;
	localparam int unsigned ERR_W = 16;
	localparam int unsigned ACC_W = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 14;

	// datapath widths of the controller math
	localparam int unsigned SUM_W = 42;
	localparam int unsigned OUT_W = 38;
	localparam int unsigned T_W = 44;

	// count / 6 by reciprocal, exact for every count below 2^COUNT_BITS
	localparam int unsigned DIV6_SHIFT = COUNT_BITS + 2;
	localparam longint unsigned DIV6_MAGIC = ((64'd1 << DIV6_SHIFT) / 6) + 1;
	localparam int unsigned QUOT6_W = COUNT_BITS - 2;

	// divide by five unit, one byte digit per step
	localparam int unsigned DIV_W = 40;
	localparam int unsigned DIGIT_W = 8;
	localparam int unsigned DIV_STEPS = DIV_W / DIGIT_W;
	localparam int unsigned REM_W = 3;
	localparam int unsigned DIV5_MAG_W = 12;
	localparam logic [DIV5_MAG_W-1:0] DIV5_MAGIC = 12'd3277;
	localparam int unsigned DIV5_SHIFT = 14;
	localparam logic [REM_W-1:0] DIV5_DIVISOR = 3'd5;

	// saturation limits
	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

	// input opcodes
	typedef enum logic [1:0] {
		OP_HALL_RIGHT = 2'd0,
		OP_HALL_LEFT  = 2'd1,
		OP_TICK       = 2'd2
	} opcode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET    = 3'd0,
		REG_THRESHOLD = 3'd1,
		REG_KP        = 3'd2,
		REG_KI        = 3'd3,
		REG_FEEDBACK  = 3'd4
	} reg_index_t;

	// configuration registers
	typedef struct packed {
		logic [TARGET_W-1:0] target_speed;
		logic [ADC_W-1:0]    enable_threshold;
		logic [GAIN_W-1:0]   kp_tenths;
		logic [GAIN_W-1:0]   ki_tenths;
		logic [FB_W-1:0]     feedback_tenths;
	} cfg_t;

	// per-lane commands from the top level
	typedef struct packed {
		logic hall;
		logic tick;
		logic enable;
	} lane_ctrl_t;

	// per-lane status toward the merge stage
	typedef struct packed {
		logic                      idle;
		logic signed [DRIVE_W-1:0] drive;
		logic [SPEED_W-1:0]        speed;
	} lane_stat_t;

endpackage

// ===== sv/dmpi_ifs.sv =====
// valid/ready channel interfaces for input items and result items
interface dmpi_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [11:0] adc_right;
	logic [11:0] adc_left;

	modport source (output valid, output opcode, output adc_right, output adc_left, input ready);
	modport sink (input valid, input opcode, input adc_right, input adc_left, output ready);
endinterface

interface dmpi_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive_right;
	logic signed [15:0] drive_left;
	logic [14:0]        speed_right;
	logic [14:0]        speed_left;

	modport source (output valid, output drive_right, output drive_left,
		output speed_right, output speed_left, input ready);
	modport sink (input valid, input drive_right, input drive_left,
		input speed_right, input speed_left, output ready);
endinterface

// ===== sv/dmpi_div5.sv =====
// multi-cycle unsigned divide by five, one byte digit per cycle
module dmpi_div5 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dmpi_pkg::DIV_W-1:0]  dividend,
	output logic                        done,
	output logic [dmpi_pkg::DIV_W-1:0]  quotient
);
	import dmpi_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);
	localparam int unsigned PART_W = REM_W + DIGIT_W;

	logic [DIV_W-1:0]             num_q;
	logic [DIV_W-1:0]             quo_q;
	logic [REM_W-1:0]             rem_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         done_q;
	logic [PART_W-1:0]            part;
	logic [PART_W+DIV5_MAG_W-1:0] prod;
	logic [DIGIT_W-1:0]           digit;
	logic [PART_W-1:0]            back;

	// remainder and next byte, digit by reciprocal, new remainder
	always_comb begin
		part  = {rem_q, num_q[DIV_W-1 -: DIGIT_W]};
		prod  = part * DIV5_MAGIC;
		digit = prod[DIV5_SHIFT +: DIGIT_W];
		back  = part - (PART_W'(digit) * PART_W'(DIV5_DIVISOR));
	end

	// step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifter, remainder and quotient digits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= num_q << DIGIT_W;
			rem_q <= back[REM_W-1:0];
			quo_q <= {quo_q[DIV_W-DIGIT_W-1:0], digit};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

// ===== sv/dmpi_lane.sv =====
// one motor lane: edge counter, speed, integral, pi output and drive update
module dmpi_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dmpi_pkg::lane_ctrl_t ctrl,
	input  dmpi_pkg::cfg_t       cfg,
	output dmpi_pkg::lane_stat_t stat
);
	import dmpi_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPEED,
		ST_ERR,
		ST_PROD,
		ST_SUM,
		ST_DIVA,
		ST_WAITA,
		ST_FB,
		ST_DIVB,
		ST_WAITB
	} state_t;

	localparam logic [COUNT_BITS-1:0] DIV6_M = COUNT_BITS'(DIV6_MAGIC);

	state_t                    state_q;
	logic [COUNT_BITS-1:0]     count_q;
	logic signed [ACC_W-1:0]   esum_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic [SPEED_W-1:0]        speed_q;

	logic signed [ERR_W-1:0]   err_s2;
	logic signed [SUM_W-1:0]   p_s3;
	logic signed [SUM_W-1:0]   i_s3;
	logic signed [SUM_W-1:0]   sum_s4;
	logic signed [OUT_W-1:0]   out_q;
	logic signed [T_W-1:0]     t_q;
	logic                      neg_q;

	logic [2*COUNT_BITS-1:0]   prod6;
	logic [COUNT_BITS-2:0]     spd_raw;
	logic [SPEED_W-1:0]        spd_next;
	logic signed [ERR_W-1:0]   err;
	logic signed [ACC_W:0]     acc_sum;
	logic signed [ACC_W-1:0]   acc_next;
	logic signed [GAIN_W:0]    kp_s;
	logic signed [GAIN_W:0]    ki_s;
	logic signed [GAIN_W+ERR_W:0] kp_e;
	logic signed [GAIN_W+ACC_W:0] ki_i;
	logic signed [FB_W:0]      fb_s;
	logic signed [FB_W+OUT_W:0] fb_o;
	logic [SUM_W-1:0]          mag_sum;
	logic [T_W-1:0]            mag_t;
	logic                      div_start;
	logic [DIV_W-1:0]          div_in;
	logic                      div_done;
	logic [DIV_W-1:0]          div_q;
	logic signed [OUT_W-1:0]   out_mag;
	logic signed [DIV_W:0]     drv_full;
	logic signed [DRIVE_W-1:0] drv_next;

	// speed from the edge count: floor(count / 6) * 2, saturated
	always_comb begin
		prod6   = count_q * DIV6_M;
		spd_raw = {prod6[DIV6_SHIFT +: QUOT6_W], 1'b0};
		if (32'(spd_raw) > 32'(SPEED_MAX)) begin
			spd_next = SPEED_MAX;
		end else begin
			spd_next = SPEED_W'(spd_raw);
		end
	end

	// speed error and saturating integral
	always_comb begin
		err     = $signed({{(ERR_W-TARGET_W){1'b0}}, cfg.target_speed})
			- $signed({{(ERR_W-SPEED_W){1'b0}}, speed_q});
		acc_sum = $signed({esum_q[ACC_W-1], esum_q}) + (ACC_W+1)'(err);
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_next = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_next = acc_sum[ACC_W-1:0];
		end
	end

	// gain products and feedback product
	always_comb begin
		kp_s = $signed({1'b0, cfg.kp_tenths});
		ki_s = $signed({1'b0, cfg.ki_tenths});
		fb_s = $signed({1'b0, cfg.feedback_tenths});
		kp_e = kp_s * err_s2;
		ki_i = ki_s * esum_q;
		fb_o = fb_s * out_q;
	end

	// magnitudes for the divider, shared by both divisions
	always_comb begin
		mag_sum   = sum_s4[SUM_W-1] ? SUM_W'(-sum_s4) : SUM_W'(sum_s4);
		mag_t     = t_q[T_W-1] ? T_W'(-t_q) : T_W'(t_q);
		div_start = (state_q == ST_DIVA) || (state_q == ST_DIVB);
		div_in    = (state_q == ST_DIVA) ? mag_sum[DIV_W+1:2] : mag_t[DIV_W:1];
	end

	dmpi_div5 u_div5 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.done     (div_done),
		.quotient (div_q)
	);

	// signed quotients and drive saturation
	always_comb begin
		out_mag  = $signed({1'b0, div_q[OUT_W-2:0]});
		drv_full = neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
		if (drv_full > (DIV_W+1)'(DRIVE_MAX)) begin
			drv_next = DRIVE_MAX;
		end else if (drv_full < (DIV_W+1)'(DRIVE_MIN)) begin
			drv_next = DRIVE_MIN;
		end else begin
			drv_next = drv_full[DRIVE_W-1:0];
		end
	end

	// sequencer and motor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			esum_q  <= '0;
			drive_q <= '0;
			speed_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.tick) begin
						if (ctrl.enable) begin
							state_q <= ST_SPEED;
						end else begin
							count_q <= '0;
						end
					end else if (ctrl.hall && (count_q != '1)) begin
						count_q <= count_q + COUNT_BITS'(1);
					end
				end
				ST_SPEED: begin
					speed_q <= spd_next;
					count_q <= '0;
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					esum_q  <= acc_next;
					state_q <= ST_PROD;
				end
				ST_PROD: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_DIVA;
				ST_DIVA: state_q <= ST_WAITA;
				ST_WAITA: begin
					if (div_done) begin
						state_q <= ST_FB;
					end
				end
				ST_FB: state_q <= ST_DIVB;
				ST_DIVB: state_q <= ST_WAITB;
				ST_WAITB: begin
					if (div_done) begin
						drive_q <= drv_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath stage registers
	always_ff @(posedge clk) begin
		if (state_q == ST_ERR) begin
			err_s2 <= err;
		end
		if (state_q == ST_PROD) begin
			p_s3 <= $signed(SUM_W'(kp_e)) <<< 1;
			i_s3 <= SUM_W'(ki_i);
		end
		if (state_q == ST_SUM) begin
			sum_s4 <= p_s3 + i_s3;
		end
		if (state_q == ST_DIVA) begin
			neg_q <= sum_s4[SUM_W-1];
		end
		if ((state_q == ST_WAITA) && div_done) begin
			out_q <= neg_q ? -out_mag : out_mag;
		end
		if (state_q == ST_FB) begin
			t_q <= T_W'(fb_o) + ($signed(T_W'(drive_q)) <<< 3) + ($signed(T_W'(drive_q)) <<< 1);
		end
		if (state_q == ST_DIVB) begin
			neg_q <= t_q[T_W-1];
		end
	end

	assign stat.idle  = (state_q == ST_IDLE);
	assign stat.drive = drive_q;
	assign stat.speed = speed_q;
endmodule

// ===== sv/dual_motor_pi_speed_control_core.sv =====
// Hall edge transaction: updates an edge count, gives no result.
// Tick transaction: the result is loaded into the output register once both lanes are idle
//   and that register is free; an enabled motor's lane first runs a sequence with two passes
//   through its five-step divide-by-five unit. The next item is taken once the
//   result sits in the output register, even while it waits there.
// arst_n clears counts, integrals, drives, speeds and loads the register defaults.
module dual_motor_pi_speed_control_core (
	input  logic                                clk,
	input  logic                                arst_n,
	dmpi_in_if.sink                             item,
	dmpi_out_if.source                          result,
	input  logic                                cfg_we,
	input  logic [dmpi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dmpi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import dmpi_pkg::*;

	cfg_t                      cfg_q;
	logic                      busy_q;
	logic                      res_valid_q;
	logic signed [DRIVE_W-1:0] res_drive_r_q;
	logic signed [DRIVE_W-1:0] res_drive_l_q;
	logic [SPEED_W-1:0]        res_speed_r_q;
	logic [SPEED_W-1:0]        res_speed_l_q;

	logic       accept;
	logic       load;
	lane_ctrl_t ctrl_r;
	lane_ctrl_t ctrl_l;
	lane_stat_t stat_r;
	lane_stat_t stat_l;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_speed     <= TARGET_W'(20);
			cfg_q.enable_threshold <= '0;
			cfg_q.kp_tenths        <= GAIN_W'(15);
			cfg_q.ki_tenths        <= GAIN_W'(8);
			cfg_q.feedback_tenths  <= FB_W'(1);
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_TARGET:    cfg_q.target_speed     <= cfg_wdata[TARGET_W-1:0];
				REG_THRESHOLD: cfg_q.enable_threshold <= cfg_wdata[ADC_W-1:0];
				REG_KP:        cfg_q.kp_tenths        <= cfg_wdata[GAIN_W-1:0];
				REG_KI:        cfg_q.ki_tenths        <= cfg_wdata[GAIN_W-1:0];
				REG_FEEDBACK:  cfg_q.feedback_tenths  <= cfg_wdata[FB_W-1:0];
				default: ;
			endcase
		end
	end

	// input decode into per-lane commands
	assign accept = item.valid && item.ready;
	assign item.ready = !busy_q;

	always_comb begin
		ctrl_r.hall   = accept && (item.opcode == OP_HALL_RIGHT);
		ctrl_r.tick   = accept && (item.opcode == OP_TICK);
		ctrl_r.enable = (item.adc_right >= cfg_q.enable_threshold);
		ctrl_l.hall   = accept && (item.opcode == OP_HALL_LEFT);
		ctrl_l.tick   = ctrl_r.tick;
		ctrl_l.enable = (item.adc_left >= cfg_q.enable_threshold);
	end

	dmpi_lane u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_r),
		.cfg    (cfg_q),
		.stat   (stat_r)
	);

	dmpi_lane u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_l),
		.cfg    (cfg_q),
		.stat   (stat_l)
	);

	// merge both lanes into the output register once they are done
	assign load = busy_q && stat_r.idle && stat_l.idle && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctrl_r.tick) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_drive_r_q <= stat_r.drive;
			res_drive_l_q <= stat_l.drive;
			res_speed_r_q <= stat_r.speed;
			res_speed_l_q <= stat_l.speed;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.drive_right = res_drive_r_q;
	assign result.drive_left  = res_drive_l_q;
	assign result.speed_right = res_speed_r_q;
	assign result.speed_left  = res_speed_l_q;
endmodule

// ===== sv/dmpi_checker.sv =====
// port-level checks for the speed control core, bound to the top level
module dmpi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [1:0]  item_opcode,
	input logic        result_valid,
	input logic        result_ready,
	input logic [61:0] result_data
);
	import dmpi_pkg::*;

	// a pending result stays offered until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before transaction");

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_data))
		else $error("result payload changed while stalled");

	// a tick blocks further input while the lanes work
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_opcode == OP_TICK) |=> !item_ready)
		else $error("input taken during a tick");

	// anything but a tick never raises a result
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_opcode != OP_TICK) && !result_valid
		|=> !result_valid)
		else $error("result without a tick");

	// reset empties the output register
	assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");
endmodule

bind dual_motor_pi_speed_control_core dmpi_checker u_dmpi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_opcode  (item.opcode),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  ({result.drive_right, result.drive_left, result.speed_right,
		result.speed_left})
);

// ===== tb/tb_top.sv =====
// self-checking testbench for the dual motor pi speed controller core
module tb_top;
	import dmpi_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 280;
	localparam int NUM_PHASES = 6;
	localparam int REPORT_LIMIT = 10;
	localparam int RUN_EDGES = 100;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint unsigned EDGE_MAX = (64'd1 << COUNT_BITS) - 1;
	localparam longint INTEG_MAX = longint'(ACC_MAX);
	localparam longint INTEG_MIN = longint'(ACC_MIN);
	localparam longint DRV_MAX = longint'(DRIVE_MAX);
	localparam longint DRV_MIN = longint'(DRIVE_MIN);

	// one tick result as the output channel carries it
	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive_right;
		logic signed [DRIVE_W-1:0] drive_left;
		logic [SPEED_W-1:0]        speed_right;
		logic [SPEED_W-1:0]        speed_left;
	} motor_status_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                 no_stall;
	int                   mismatch_count;
	int                   idle_cycles;

	dmpi_in_if  item_ch();
	dmpi_out_if status_ch();

	dual_motor_pi_speed_control_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (status_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// controller state mirror
	cfg_t            cfg_mirror;
	longint unsigned edge_total [2];
	longint          integ_half [2];
	longint          drive_now [2];
	longint          speed_now [2];
	motor_status_t   expected_status [$];

	// advance the mirror by one accepted item and queue the status a tick produces
	function automatic void advance_controller(logic [1:0] op, logic [ADC_W-1:0] adc_r,
		logic [ADC_W-1:0] adc_l);
		logic [ADC_W-1:0] adc [2];
		longint spd, err, ih, outv, drv;
		motor_status_t want;
		adc[0] = adc_r;
		adc[1] = adc_l;
		case (op)
			OP_HALL_RIGHT, OP_HALL_LEFT: begin
				if (edge_total[op[0]] < EDGE_MAX)
					edge_total[op[0]]++;
			end
			OP_TICK: begin
				for (int m = 0; m < 2; m++) begin
					if (adc[m] >= cfg_mirror.enable_threshold) begin
						spd = longint'((edge_total[m] / 6) * 2);
						if (spd > longint'(SPEED_MAX))
							spd = longint'(SPEED_MAX);
						speed_now[m] = spd;
						err = longint'(cfg_mirror.target_speed) - spd;
						// integral in half units, saturating to 32 bits
						ih = integ_half[m] + err;
						if (ih > INTEG_MAX)
							ih = INTEG_MAX;
						else if (ih < INTEG_MIN)
							ih = INTEG_MIN;
						integ_half[m] = ih;
						// divisions truncate toward zero
						outv = (2 * longint'(cfg_mirror.kp_tenths) * err
							+ longint'(cfg_mirror.ki_tenths) * ih) / 20;
						drv = (10 * drive_now[m] + longint'(cfg_mirror.feedback_tenths) * outv) / 10;
						if (drv > DRV_MAX)
							drv = DRV_MAX;
						else if (drv < DRV_MIN)
							drv = DRV_MIN;
						drive_now[m] = drv;
					end
				end
				edge_total[0] = 0;
				edge_total[1] = 0;
				want.drive_right = drive_now[0][DRIVE_W-1:0];
				want.drive_left = drive_now[1][DRIVE_W-1:0];
				want.speed_right = speed_now[0][SPEED_W-1:0];
				want.speed_left = speed_now[1][SPEED_W-1:0];
				expected_status.push_back(want);
			end
			default: ;
		endcase
	endfunction

	function automatic void note_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("MISMATCH: %s", msg);
	endfunction

	function automatic void compare_field(string name, logic [DRIVE_W-1:0] got,
		logic [DRIVE_W-1:0] want);
		if (got !== want)
			note_failure($sformatf("%s expected %h got %h", name, want, got));
	endfunction

	// compare one accepted status transaction with the oldest expectation
	function automatic void check_status();
		motor_status_t want;
		if (expected_status.size() == 0) begin
			note_failure("status transaction with no tick pending");
			return;
		end
		want = expected_status.pop_front();
		compare_field("drive_right", status_ch.drive_right, want.drive_right);
		compare_field("drive_left", status_ch.drive_left, want.drive_left);
		compare_field("speed_right", {1'b0, status_ch.speed_right}, {1'b0, want.speed_right});
		compare_field("speed_left", {1'b0, status_ch.speed_left}, {1'b0, want.speed_left});
	endfunction

	// result sink back-pressure
	always @(negedge clk)
		status_ch.ready <= no_stall || ($urandom_range(0, 99) >= 30);

	// result checking and watchdog
	always @(posedge clk) begin
		if (arst_n && status_ch.valid && status_ch.ready)
			check_status();
		if ((item_ch.valid && item_ch.ready) || (status_ch.valid && status_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// drive one item until accepted; valid stays high on return
	task automatic send_item(logic [1:0] op, logic [ADC_W-1:0] adc_r, logic [ADC_W-1:0] adc_l);
		@(negedge clk);
		while (!no_stall && $urandom_range(0, 99) < 30) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= op;
		item_ch.adc_right <= adc_r;
		item_ch.adc_left <= adc_l;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		advance_controller(op, adc_r, adc_l);
	endtask

	task automatic send_edge(logic [1:0] op);
		send_item(op, ADC_W'($urandom_range(0, 4095)), ADC_W'($urandom_range(0, 4095)));
	endtask

	task automatic stop_items();
		@(negedge clk);
		item_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	// quiet the block before a register write or the end of the run
	task automatic settle();
		stop_items();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
	endtask

	task automatic apply_config(cfg_t c);
		put_reg(REG_TARGET, CFG_DATA_W'(c.target_speed));
		put_reg(REG_THRESHOLD, CFG_DATA_W'(c.enable_threshold));
		put_reg(REG_KP, CFG_DATA_W'(c.kp_tenths));
		put_reg(REG_KI, CFG_DATA_W'(c.ki_tenths));
		put_reg(REG_FEEDBACK, CFG_DATA_W'(c.feedback_tenths));
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_mirror = c;
	endtask

	function automatic int unsigned pick_value(int unsigned hi);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return hi;
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	// reset defaults, an unused opcode and a short edge count
	task automatic test_defaults();
		repeat (6) send_edge(OP_HALL_RIGHT);
		send_edge(OP_HALL_LEFT);
		send_edge(OP_UNUSED);
		send_item(OP_TICK, 12'd0, 12'd4095);
		settle();
	endtask

	// gains and setpoint at both ends, one motor disabled, feedback above ten
	task automatic test_gain_extremes();
		apply_config('{14'd16383, 12'd4095, 8'd255, 8'd255, 4'd15});
		send_item(OP_TICK, 12'd4095, 12'd4094);
		send_item(OP_TICK, 12'd4095, 12'd4095);
		settle();
		apply_config('{14'd0, 12'd0, 8'd0, 8'd0, 4'd0});
		send_item(OP_TICK, 12'd0, 12'd0);
		settle();
	endtask

	// long back to back edge runs on both motors, then drive hard negative
	task automatic test_edge_saturation();
		apply_config('{14'd0, 12'd0, 8'd255, 8'd0, 4'd15});
		no_stall = 1'b1;
		for (int i = 0; i < RUN_EDGES; i++) begin
			send_edge(OP_HALL_RIGHT);
			send_edge(OP_HALL_LEFT);
		end
		send_item(OP_TICK, ADC_W'($urandom_range(0, 4095)), ADC_W'($urandom_range(0, 4095)));
		repeat (6) send_edge(OP_HALL_RIGHT);
		send_item(OP_TICK, ADC_W'($urandom_range(0, 4095)), ADC_W'($urandom_range(0, 4095)));
		no_stall = 1'b0;
		settle();
	endtask

	// bursts of hall edges closed by a tick, under changing settings
	task automatic test_random_traffic();
		cfg_t c;
		int   sent;
		int   burst;
		int   share;
		bit   drained_once;
		drained_once = 1'b0;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: c = '{14'd16383, 12'd0, 8'd255, 8'd255, 4'd15};
				1: c = '{14'd0, 12'd4095, 8'd0, 8'd0, 4'd0};
				default: begin
					c.target_speed = TARGET_W'(pick_value(16383));
					c.enable_threshold = ADC_W'(pick_value(4095));
					c.kp_tenths = GAIN_W'(pick_value(255));
					c.ki_tenths = GAIN_W'(pick_value(255));
					c.feedback_tenths = FB_W'(pick_value(15));
				end
			endcase
			apply_config(c);
			no_stall = (phase == 3);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 150)
					: $urandom_range(0, 12);
				share = $urandom_range(0, 100);
				repeat (burst)
					send_edge(($urandom_range(0, 99) < share) ? OP_HALL_RIGHT : OP_HALL_LEFT);
				if ($urandom_range(0, 19) == 0)
					send_edge(OP_UNUSED);
				send_item(OP_TICK, ADC_W'($urandom_range(0, 4095)),
					ADC_W'($urandom_range(0, 4095)));
				sent += burst + 1;
				// hold the sender until every pending result is out
				if (phase == 2 && !drained_once && sent >= ITEMS_PER_PHASE / 2) begin
					stop_items();
					wait_drained();
					drained_once = 1'b1;
				end
			end
			no_stall = 1'b0;
			settle();
		end
	endtask

	// reset, tests in turn, final verdict
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		no_stall = 1'b0;
		mismatch_count = 0;
		idle_cycles = 0;
		item_ch.valid = 1'b0;
		item_ch.opcode = '0;
		item_ch.adc_right = '0;
		item_ch.adc_left = '0;
		status_ch.ready = 1'b0;
		cfg_mirror = '{14'd20, 12'd0, 8'd15, 8'd8, 4'd1};
		for (int m = 0; m < 2; m++) begin
			edge_total[m] = 0;
			integ_half[m] = 0;
			drive_now[m] = 0;
			speed_now[m] = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_gain_extremes();
		test_edge_saturation();
		test_random_traffic();

		settle();
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/dmpi_pkg.sv
sv/dmpi_ifs.sv
sv/dmpi_div5.sv
sv/dmpi_lane.sv
sv/dual_motor_pi_speed_control_core.sv
sv/dmpi_checker.sv
tb/tb_top.sv
